@@ rtl/core/fidl_pkg.sv @@
// shared constants, types and helpers for the framed id line receiver
`timescale 1ns / 1ps

package fidl_pkg;

    localparam int ID_LEN       = 26;
    localparam int LINE_BUF_LEN = 64;
    localparam int MARK_LEN     = 4;
    localparam int FRAME_LEN    = 2 * MARK_LEN + ID_LEN;

    localparam int POS_W = $clog2(LINE_BUF_LEN);
    localparam int ID_AW = (ID_LEN > 1) ? $clog2(ID_LEN) : 1;

    localparam logic [7:0] CH_CR         = 8'd13;
    localparam logic [7:0] CH_LF         = 8'd10;
    localparam logic [7:0] MARKER_RESET  = 8'd35;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_LOAD,
        EM_SEND
    } t_emit_state;

    typedef struct packed {
        logic             en;
        logic [ID_AW-1:0] addr;
        logic [7:0]       data;
    } t_wr_req;

    typedef struct packed {
        logic             en;
        logic [ID_AW-1:0] addr;
    } t_rd_req;

    function automatic logic is_alnum(input logic [7:0] c);
        logic dig;
        logic low;
        logic upp;
        dig = (c >= 8'h30) && (c <= 8'h39);
        low = (c >= 8'h61) && (c <= 8'h7a);
        upp = (c >= 8'h41) && (c <= 8'h5a);
        return dig || low || upp;
    endfunction

endpackage

@@ rtl/core/fidl_id_ram.sv @@
// identifier character memory, one write port and one registered read port
`timescale 1ns / 1ps

module fidl_id_ram (
    input  logic             i_clk,
    input  fidl_pkg::t_wr_req i_wr,
    input  fidl_pkg::t_rd_req i_rd,
    output logic [7:0]       o_rd_data
);
    import fidl_pkg::*;

    logic [7:0] r_mem [ID_LEN];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/fidl_emitter.sv @@
// read-out sequencer: walks the id memory and drives the result channel
`timescale 1ns / 1ps

module fidl_emitter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output fidl_pkg::t_rd_req o_rd,
    input  logic [7:0]        i_rd_data,
    output logic              o_busy,
    output logic              o_id_valid,
    input  logic              i_id_ready,
    output logic [7:0]        o_id_char,
    output logic              o_id_last
);
    import fidl_pkg::*;

    localparam logic [ID_AW-1:0] LAST_IDX = ID_AW'(ID_LEN - 1);

    t_emit_state      r_state, n_state;
    logic [ID_AW-1:0] r_idx, n_idx;
    logic [7:0]       r_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= EM_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_rd    = '0;
        case (r_state)
            EM_IDLE: begin
                if (i_start) begin
                    o_rd.en = 1'b1;
                    n_idx   = '0;
                    n_state = EM_LOAD;
                end
            end
            EM_LOAD: begin
                n_state = EM_SEND;
            end
            EM_SEND: begin
                if (i_id_ready) begin
                    if (r_idx == LAST_IDX) begin
                        n_state = EM_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        o_rd.en = 1'b1;
                        n_state = EM_LOAD;
                    end
                end
            end
            default: begin
                n_state = EM_IDLE;
            end
        endcase
        o_rd.addr = n_idx;
    end

    // capture the memory word in the cycle after its read
    always_ff @(posedge i_clk) begin
        if (r_state == EM_LOAD) begin
            r_char <= i_rd_data;
        end
    end

    assign o_busy     = (r_state != EM_IDLE);
    assign o_id_valid = (r_state == EM_SEND);
    assign o_id_char  = r_char;
    assign o_id_last  = (r_idx == LAST_IDX);

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == EM_IDLE))
        else $error("emission started while busy");

    a_load_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == EM_LOAD) |=> (r_state == EM_SEND))
        else $error("loaded character not presented");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_id_valid && i_id_ready && o_id_last) |=> (r_state == EM_IDLE))
        else $error("emission continued past last character");

endmodule

@@ rtl/core/framed_id_line_receiver_unit.sv @@
// framed id line receiver: line assembly, frame check and id read-out
`timescale 1ns / 1ps
// read-out: after the line feed of a good line the first id character passes the memory
//   read register and the emitter output register before it is valid
// throughput: one byte per cycle while no id is being sent; each id character passes a
//   memory read and the output register, input is held off for the run
// reset: synchronous active low; clears line position, frame check and marker ('#'),
//   the id memory is not cleared

module framed_id_line_receiver_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_id_valid,
    input  logic       i_id_ready,
    output logic [7:0] o_id_char,
    output logic       o_id_last
);
    import fidl_pkg::*;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_BUF_LEN - 1);

    logic [7:0]       r_marker;
    logic [POS_W-1:0] r_line_pos, n_line_pos;
    logic             r_frame_ok, n_frame_ok;

    logic             rx_xfer;
    logic             in_frame;
    logic             is_mark_pos;
    logic             good;
    logic             emit_start;
    logic             emit_busy;
    t_wr_req          wr_req;
    t_rd_req          rd_req;
    logic [7:0]       rd_data;

    // marker register, to be written only while idle; the block itself does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker <= MARKER_RESET;
        end else if (i_cfg_wr_en) begin
            r_marker <= i_cfg_wr_data;
        end
    end

    // no input while the id run is read out, so the memory stays stable
    assign o_rx_ready = !emit_busy;
    assign rx_xfer    = i_rx_valid && o_rx_ready;

    assign in_frame    = (int'(r_line_pos) < FRAME_LEN);
    assign is_mark_pos = (int'(r_line_pos) < MARK_LEN) ||
                         (int'(r_line_pos) >= MARK_LEN + ID_LEN);
    assign good        = is_mark_pos ? (i_rx_byte == r_marker) : is_alnum(i_rx_byte);

    // only identifier positions of a data byte reach the memory
    always_comb begin
        wr_req.en   = rx_xfer && (i_rx_byte != CH_CR) && (i_rx_byte != CH_LF) &&
                      in_frame && !is_mark_pos;
        wr_req.addr = ID_AW'(int'(r_line_pos) - MARK_LEN);
        wr_req.data = i_rx_byte;
    end

    // line position and running frame check; a wrap restarts both at position 0,
    // so reaching the frame length means every frame position was written this pass
    always_comb begin
        n_line_pos = r_line_pos;
        n_frame_ok = r_frame_ok;
        emit_start = 1'b0;
        if (rx_xfer) begin
            if (i_rx_byte == CH_LF) begin
                n_line_pos = '0;
                emit_start = (int'(r_line_pos) == FRAME_LEN) && r_frame_ok;
            end else if (i_rx_byte != CH_CR) begin
                if (r_line_pos == '0) begin
                    n_frame_ok = good;
                end else if (in_frame) begin
                    n_frame_ok = r_frame_ok && good;
                end
                n_line_pos = (r_line_pos == POS_LAST) ? '0 : r_line_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_pos <= '0;
            r_frame_ok <= 1'b0;
        end else begin
            r_line_pos <= n_line_pos;
            r_frame_ok <= n_frame_ok;
        end
    end

    fidl_id_ram u_id_ram (
        .i_clk     (i_clk),
        .i_wr      (wr_req),
        .i_rd      (rd_req),
        .o_rd_data (rd_data)
    );

    fidl_emitter u_emitter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (emit_start),
        .o_rd       (rd_req),
        .i_rd_data  (rd_data),
        .o_busy     (emit_busy),
        .o_id_valid (o_id_valid),
        .i_id_ready (i_id_ready),
        .o_id_char  (o_id_char),
        .o_id_last  (o_id_last)
    );

    a_no_wr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_req.en |-> !emit_busy)
        else $error("id memory written during read-out");

    a_lf_resets_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rx_xfer && (i_rx_byte == CH_LF)) |=> (r_line_pos == '0))
        else $error("line position not cleared after line feed");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_start |=> emit_busy)
        else $error("accepted line did not start read-out");

endmodule

@@ bench/framed_id_line_receiver_unit_test.sv @@
// self-checking testbench for the framed id line receiver
`timescale 1ns / 1ps

module framed_id_line_receiver_unit_test;

    import fidl_pkg::*;

    // kinds of line the stimulus can build
    typedef enum int {
        LN_GOOD,
        LN_EDGE,
        LN_EDGE_BAD,
        LN_BAD_ID,
        LN_BAD_MARK,
        LN_SHORT,
        LN_LONG,
        LN_WRAP,
        LN_NOISE
    } t_line_kind;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_id_result;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_wr_en   = 1'b0;
    logic [7:0] i_cfg_wr_data = 8'd0;
    logic       i_rx_valid    = 1'b0;
    logic       o_rx_ready;
    logic [7:0] i_rx_byte     = 8'd0;
    logic       o_id_valid;
    logic       i_id_ready    = 1'b0;
    logic [7:0] o_id_char;
    logic       o_id_last;

    // byte stream waiting to go out, and id characters the block owes us
    logic [7:0] rx_pending_q[$];
    t_id_result id_expect_q[$];

    // shadow of the block: marker register, write position, per-slot verdicts, id bytes
    logic [7:0] shadow_marker;
    int         shadow_pos;
    logic       slot_ok[FRAME_LEN];
    logic [7:0] id_mem[ID_LEN];

    bit calm = 1'b0;   // no gaps and no stalls while set
    int rx_gap;
    int id_stall;
    int err_count;
    int bytes_taken;
    int lines_taken;
    int lines_dropped;
    int ids_checked;

    framed_id_line_receiver_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_rx_valid   (i_rx_valid),
        .o_rx_ready   (o_rx_ready),
        .i_rx_byte    (i_rx_byte),
        .o_id_valid   (o_id_valid),
        .i_id_ready   (i_id_ready),
        .o_id_char    (o_id_char),
        .o_id_last    (o_id_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic id_char_legal(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic [7:0] pick_alnum();
        int r;
        r = $urandom_range(0, 61);
        if (r < 10) return 8'("0" + r);
        if (r < 36) return 8'("a" + r - 10);
        return 8'("A" + r - 36);
    endfunction

    // any byte that neither ends the line nor gets skipped
    function automatic logic [7:0] pick_plain();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_CR || b == CH_LF);
        return b;
    endfunction

    // the alnum range boundaries, and the bytes right outside them
    function automatic logic [7:0] edge_char(input int k, input logic legal);
        case (k % 6)
            0: return legal ? 8'h30 : 8'h2f;
            1: return legal ? 8'h39 : 8'h3a;
            2: return legal ? 8'h61 : 8'h60;
            3: return legal ? 8'h7a : 8'h7b;
            4: return legal ? 8'h41 : 8'h40;
            default: return legal ? 8'h5a : 8'h5b;
        endcase
    endfunction

    // line model: advances position, records slot verdicts, checks the frame on line feed
    task automatic predict_rx(input logic [7:0] c);
        logic framed;
        int   k;
        if (c == CH_CR) return;
        if (c == CH_LF) begin
            framed = (shadow_pos == FRAME_LEN);
            shadow_pos = 0;
            for (k = 0; k < FRAME_LEN; k++)
                if (!slot_ok[k]) framed = 1'b0;
            if (!framed) begin
                lines_dropped++;
                return;
            end
            lines_taken++;
            for (k = 0; k < ID_LEN; k++)
                id_expect_q.push_back('{ch: id_mem[k], last: (k == ID_LEN - 1)});
            return;
        end
        if (shadow_pos < FRAME_LEN) begin
            if (shadow_pos < MARK_LEN || shadow_pos >= MARK_LEN + ID_LEN) begin
                slot_ok[shadow_pos] = (c == shadow_marker);
            end else begin
                slot_ok[shadow_pos] = id_char_legal(c);
                id_mem[shadow_pos - MARK_LEN] = c;
            end
        end
        shadow_pos = (shadow_pos >= LINE_BUF_LEN - 1) ? 0 : shadow_pos + 1;
    endtask

    // build one line of the given kind and queue it, with a stray carriage return here and there
    task automatic add_line(input t_line_kind kind, input logic [7:0] mk);
        logic [7:0] fr[$];
        int         k;
        int         n;
        for (k = 0; k < MARK_LEN; k++) fr.push_back(mk);
        for (k = 0; k < ID_LEN; k++) begin
            if (kind == LN_EDGE) fr.push_back(edge_char(k, 1'b1));
            else if (kind == LN_EDGE_BAD) fr.push_back(edge_char(k, k != 3));
            else fr.push_back(pick_alnum());
        end
        for (k = 0; k < MARK_LEN; k++) fr.push_back(mk);
        case (kind)
            LN_BAD_ID: begin
                n = MARK_LEN + $urandom_range(0, ID_LEN - 1);
                do fr[n] = pick_plain(); while (id_char_legal(fr[n]));
            end
            LN_BAD_MARK: begin
                n = $urandom_range(0, 2 * MARK_LEN - 1);
                if (n >= MARK_LEN) n = n + ID_LEN;
                do fr[n] = pick_plain(); while (fr[n] == mk);
            end
            LN_SHORT: begin
                n = $urandom_range(1, FRAME_LEN - 1);
                repeat (n) void'(fr.pop_back());
            end
            LN_LONG: begin
                n = $urandom_range(1, 20);
                repeat (n) fr.push_back(pick_plain());
            end
            LN_WRAP: begin
                // one full buffer pass of junk, then the frame lands on the wrapped pass
                repeat (LINE_BUF_LEN) fr.push_front(pick_plain());
            end
            LN_NOISE: begin
                fr.delete();
                n = $urandom_range(0, 40);
                repeat (n) fr.push_back(8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
        foreach (fr[k]) begin
            if (!calm && $urandom_range(0, 15) == 0) rx_pending_q.push_back(CH_CR);
            rx_pending_q.push_back(fr[k]);
        end
        rx_pending_q.push_back(CH_LF);
    endtask

    function automatic t_line_kind pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return LN_GOOD;
        if (r < 68) return LN_BAD_ID;
        if (r < 76) return LN_BAD_MARK;
        if (r < 83) return LN_SHORT;
        if (r < 89) return LN_LONG;
        if (r < 93) return LN_WRAP;
        return LN_NOISE;
    endfunction

    // wait until every byte is in and every id character is out, then let the block go quiet
    task automatic settle();
        do @(negedge i_clk);
        while (rx_pending_q.size() != 0 || i_rx_valid || id_expect_q.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_marker(input logic [7:0] v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        @(negedge i_clk);
    endtask

    // byte driver: holds a pending transfer, otherwise inserts a gap or sends the next byte
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rx_valid <= 1'b0;
            rx_gap = 0;
        end else if (!(i_rx_valid && !o_rx_ready)) begin
            if (rx_gap > 0) begin
                i_rx_valid <= 1'b0;
                rx_gap = rx_gap - 1;
            end else if (rx_pending_q.size() != 0) begin
                i_rx_valid <= 1'b1;
                i_rx_byte  <= rx_pending_q.pop_front();
                rx_gap = pick_gap();
            end else begin
                i_rx_valid <= 1'b0;
            end
        end
    end

    // id side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_id_ready <= 1'b0;
            id_stall = 0;
        end else if (id_stall > 0) begin
            i_id_ready <= 1'b0;
            id_stall = id_stall - 1;
        end else begin
            i_id_ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) id_stall = pick_gap();
        end
    end

    // monitor: tracks register writes and byte transfers, checks every id transfer
    always @(posedge i_clk) begin
        t_id_result want;
        if (!i_rst_n) begin
            shadow_marker = MARKER_RESET;
            shadow_pos = 0;
            foreach (slot_ok[k]) slot_ok[k] = 1'b0;
        end else begin
            if (i_cfg_wr_en) shadow_marker = i_cfg_wr_data;
            if (i_rx_valid && o_rx_ready) begin
                bytes_taken++;
                predict_rx(i_rx_byte);
            end
            if (o_id_valid && i_id_ready) begin
                if (id_expect_q.size() == 0) begin
                    $error("unexpected id transfer: id_char %h id_last %b", o_id_char, o_id_last);
                    err_count++;
                end else begin
                    want = id_expect_q.pop_front();
                    ids_checked++;
                    if (o_id_char !== want.ch) begin
                        $error("id_char: expected %h, got %h", want.ch, o_id_char);
                        err_count++;
                    end
                    if (o_id_last !== want.last) begin
                        $error("id_last: expected %b, got %b", want.last, o_id_last);
                        err_count++;
                    end
                end
            end
        end
    end

    // stimulus and end of run
    initial begin
        logic [7:0] mk;
        int         ph;
        int         start;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed lines under the reset marker
        rx_pending_q.push_back(CH_LF);
        rx_pending_q.push_back(CH_CR);
        add_line(LN_EDGE, MARKER_RESET);
        add_line(LN_EDGE_BAD, MARKER_RESET);
        settle();

        // prefix and id checked under one marker, suffix under the next: still accepted
        repeat (MARK_LEN) rx_pending_q.push_back(MARKER_RESET);
        repeat (ID_LEN) rx_pending_q.push_back(pick_alnum());
        settle();
        write_marker(8'hff);
        repeat (MARK_LEN) rx_pending_q.push_back(8'hff);
        rx_pending_q.push_back(CH_LF);
        settle();

        // marker at the low extreme, on a wrapped line
        write_marker(8'h00);
        add_line(LN_WRAP, 8'h00);
        settle();

        // random phases, the second with no idling at all
        for (ph = 0; ph < 2; ph++) begin
            mk = ($urandom_range(0, 2) == 0) ? MARKER_RESET : 8'($urandom_range(0, 255));
            write_marker(mk);
            calm = (ph == 1);
            start = bytes_taken;
            while (bytes_taken + rx_pending_q.size() - start < 30)
                add_line(pick_kind(), mk);
            settle();
        end
        calm = 1'b0;

        $display("covered %0d byte transfers: %0d lines accepted, %0d dropped",
                 bytes_taken, lines_taken, lines_dropped);
        $display("checked %0d id character transfers", ids_checked);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
